// ===== rtl/alec_pkg.sv =====
// ----------------------------------------------------------------------------
// alec_pkg: shared definitions for the array list engine
// Request codes, status codes, widths and the per-cell control bundle.
// ----------------------------------------------------------------------------
package alec_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int VALUE_W       = 32;
  localparam int FUNC_W        = 3;
  localparam int STATUS_W      = 2;

  // Request codes
  localparam logic [FUNC_W-1:0] FN_CLEAR         = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INSERT        = 3'd1;
  localparam logic [FUNC_W-1:0] FN_DELETE        = 3'd2;
  localparam logic [FUNC_W-1:0] FN_LOCATE        = 3'd3;
  localparam logic [FUNC_W-1:0] FN_INSERT_SORTED = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BADPOS   = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd3;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_FROM_LO,
    OP_FROM_HI
  } cell_op_t;

  typedef struct packed {
    logic     cmp_en;
    logic     valid;
    cell_op_t op;
  } cell_ctrl_t;

endpackage

// ===== rtl/alec_cell.sv =====
// ----------------------------------------------------------------------------
// alec_cell: one list slot
// Holds one entry, compares it against the request value, and takes a new
// entry from the request or from either neighbour.
// ----------------------------------------------------------------------------
module alec_cell (
  input  logic                                  clk,
  input  alec_pkg::cell_ctrl_t                  ctrl,
  input  logic signed [alec_pkg::VALUE_W-1:0]   cmp_value,
  input  logic signed [alec_pkg::VALUE_W-1:0]   load_value,
  input  logic signed [alec_pkg::VALUE_W-1:0]   lo_data,
  input  logic signed [alec_pkg::VALUE_W-1:0]   hi_data,
  output logic signed [alec_pkg::VALUE_W-1:0]   data,
  output logic                                  eq_flag,
  output logic                                  le_flag
);
  import alec_pkg::*;

  logic signed [VALUE_W-1:0] data_r, data_nxt;
  logic                      eq_r, le_r;

  always_comb begin
    case (ctrl.op)
      OP_LOAD:    data_nxt = load_value;
      OP_FROM_LO: data_nxt = lo_data;
      OP_FROM_HI: data_nxt = hi_data;
      default:    data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    // flags are meaningful only for occupied slots
    if (ctrl.cmp_en) begin
      eq_r <= ctrl.valid && (data_r == cmp_value);
      le_r <= ctrl.valid && (data_r <= cmp_value);
    end
  end

  assign data    = data_r;
  assign eq_flag = eq_r;
  assign le_flag = le_r;

endmodule

// ===== rtl/array_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// array_list_engine_core: bounded ordered list of signed 32-bit values
// A row of DEPTH slots that clears, inserts, deletes, locates and inserts in
// ascending order, one request at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_func, in_value and in_position with start high; the item is
//   taken at a clock edge where busy is low. busy stays high for one cycle.
//   Every item returns exactly one result: out_status, out_index and
//   out_length are shown for a single cycle with out_strobe high, once
//   the item has left the execute state. The receiver cannot stall; it must
//   take the result in that cycle.
//   The accepting edge registers the per-slot compare flags against
//   in_value; the execute state resolves the slot index from those flags
//   and moves the row (shift up, shift down, load). Items do not overlap:
//   a new item may be accepted in the cycle the previous result is shown.
//   Reset (rst_n low, synchronous) empties the list and drops any item in
//   flight; slot contents are not cleared and are never read before they
//   are written.
// ----------------------------------------------------------------------------
module array_list_engine_core #(
  parameter int DEPTH = alec_pkg::DEPTH_DEFAULT,
  parameter int PW    = $clog2(DEPTH),
  parameter int LW    = $clog2(DEPTH + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [alec_pkg::FUNC_W-1:0]          in_func,
  input  logic signed [alec_pkg::VALUE_W-1:0]  in_value,
  input  logic [PW-1:0]                        in_position,
  output logic                                 out_strobe,
  output logic [alec_pkg::STATUS_W-1:0]        out_status,
  output logic [PW-1:0]                        out_index,
  output logic [LW-1:0]                        out_length
);
  import alec_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;

  logic                      accept;
  logic [FUNC_W-1:0]         func_r;
  logic signed [VALUE_W-1:0] value_r;
  logic [PW-1:0]             position_r;
  logic [LW-1:0]             occ_r, occ_nxt;
  logic                      busy_r;
  logic                      strobe_r;
  logic [STATUS_W-1:0]       status_r, status_nxt;
  logic [PW-1:0]             index_r, index_nxt;

  cell_ctrl_t                cell_ctrl [DEPTH];
  logic signed [VALUE_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]          eq_vec, le_vec;

  logic [DEPTH-1:0] le_rev, le_rev_iso, eq_iso;
  logic [PW-1:0]    hi_idx, loc_idx;
  logic [LW-1:0]    sorted_pos, ins_pos, pos_ext;
  logic             full, do_ins, do_del;

  assign accept = start && !busy_r;

  // Highest occupied slot with entry <= value, and first slot equal to value
  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      le_rev[j] = le_vec[DEPTH-1-j];
    end
    le_rev_iso = le_rev & ((~le_rev) + DEPTH'(1));
    eq_iso     = eq_vec & ((~eq_vec) + DEPTH'(1));
    hi_idx  = '0;
    loc_idx = '0;
    for (int j = 0; j < DEPTH; j++) begin
      hi_idx  = hi_idx  | (le_rev_iso[DEPTH-1-j] ? PW'(j) : '0);
      loc_idx = loc_idx | (eq_iso[j] ? PW'(j) : '0);
    end
    sorted_pos = (|le_vec) ? (LW'(hi_idx) + LW'(1)) : '0;
  end

  always_comb begin
    pos_ext    = LW'(position_r);
    full       = (occ_r == LW'(DEPTH));
    do_ins     = 1'b0;
    do_del     = 1'b0;
    ins_pos    = pos_ext;
    occ_nxt    = occ_r;
    status_nxt = STAT_OK;
    index_nxt  = '0;
    case (func_r)
      FN_CLEAR: begin
        occ_nxt = '0;
      end
      FN_INSERT: begin
        if (full) begin
          status_nxt = STAT_FULL;
        end else if (pos_ext > occ_r) begin
          status_nxt = STAT_BADPOS;
        end else begin
          do_ins    = 1'b1;
          occ_nxt   = occ_r + LW'(1);
          index_nxt = position_r;
        end
      end
      FN_DELETE: begin
        if (pos_ext >= occ_r) begin
          status_nxt = STAT_BADPOS;
        end else begin
          do_del    = 1'b1;
          occ_nxt   = occ_r - LW'(1);
          index_nxt = position_r;
        end
      end
      FN_LOCATE: begin
        if (|eq_vec) begin
          index_nxt = loc_idx;
        end else begin
          status_nxt = STAT_NOTFOUND;
        end
      end
      FN_INSERT_SORTED: begin
        ins_pos = sorted_pos;
        if (full) begin
          status_nxt = STAT_FULL;
        end else begin
          do_ins    = 1'b1;
          occ_nxt   = occ_r + LW'(1);
          index_nxt = PW'(sorted_pos);
        end
      end
      default: begin
        status_nxt = STAT_OK;
      end
    endcase
  end

  // Row of slots
  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    logic signed [VALUE_W-1:0] lo_data, hi_data;

    if (j == 0) begin : g_lo_edge
      assign lo_data = cell_data[j];
    end else begin : g_lo
      assign lo_data = cell_data[j-1];
    end

    if (j == DEPTH - 1) begin : g_hi_edge
      assign hi_data = cell_data[j];
    end else begin : g_hi
      assign hi_data = cell_data[j+1];
    end

    always_comb begin
      cell_ctrl[j].cmp_en = accept;
      cell_ctrl[j].valid  = (LW'(j) < occ_r);
      cell_ctrl[j].op     = OP_HOLD;
      if (state_r == S_EXEC) begin
        if (do_ins) begin
          if (LW'(j) == ins_pos) begin
            cell_ctrl[j].op = OP_LOAD;
          end else if (LW'(j) > ins_pos) begin
            cell_ctrl[j].op = OP_FROM_LO;
          end
        end else if (do_del && (LW'(j) >= pos_ext)) begin
          cell_ctrl[j].op = OP_FROM_HI;
        end
      end
    end

    alec_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[j]),
      .cmp_value  (in_value),
      .load_value (value_r),
      .lo_data    (lo_data),
      .hi_data    (hi_data),
      .data       (cell_data[j]),
      .eq_flag    (eq_vec[j]),
      .le_flag    (le_vec[j])
    );
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      occ_r    <= '0;
      busy_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= (state_r == S_EXEC);
      if (accept) begin
        busy_r <= 1'b1;
      end
      if (state_r == S_EXEC) begin
        occ_r  <= occ_nxt;
        busy_r <= 1'b0;
      end
    end
  end

  // Payload registers: hold the item and the result
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r     <= in_func;
      value_r    <= in_value;
      position_r <= in_position;
    end
    if (state_r == S_EXEC) begin
      status_r <= status_nxt;
      index_r  <= index_nxt;
    end
  end

  assign busy       = busy_r;
  assign out_strobe = strobe_r;
  assign out_status = status_r;
  assign out_index  = index_r;
  assign out_length = occ_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= LW'(DEPTH))
    else $error("occupancy above depth");

  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##2 out_strobe)
    else $error("result not returned two cycles after accept");

  a_single_exec: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while busy");

  a_full_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status == STAT_FULL)) |-> (out_length == LW'(DEPTH)))
    else $error("full reported with spare room");

endmodule
